// ===== design/kam_pkg.sv =====
package kam_pkg;

  localparam int MAX_KEYWORDS = 8;
  localparam int MAX_KEY_LEN  = 32;

  localparam int LEN_W  = $clog2(MAX_KEY_LEN + 1);
  localparam int CNT_W  = $clog2(MAX_KEYWORDS + 1);
  localparam int SLOT_W = (MAX_KEYWORDS > 1) ? $clog2(MAX_KEYWORDS) : 1;

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_HEADER  = 2'd2,
    OP_PAYLOAD = 2'd3
  } op_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  // Byte 0 is the newest byte: keywords are stored in window order.
  typedef logic [MAX_KEY_LEN-1:0][7:0]  key_t;
  typedef logic [MAX_KEYWORDS-1:0][7:0] code_vec_t;

  typedef struct packed {
    logic              remove;
    logic [SLOT_W-1:0] slot;
  } table_edit_t;

  typedef struct packed {
    logic              valid;
    logic              alert;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        code;
    logic [31:0]       src;
    logic [31:0]       dst;
  } verdict_t;

endpackage

// ===== design/packet_keyword_alert_matcher.sv =====
// Packet keyword alert matcher.
//
// Input channel (in_valid / in_stall) carries one word per cycle: add or
// remove keyword bytes, a packet header, or payload bytes. Keyword bytes
// collect in a staging buffer; the word with last set applies the command
// and yields one status word. A header opens a packet if it is IPv4/TCP and
// its address pair differs from the last alerted pair; payload bytes shift
// through a window compared against every keyword slot at once. The last
// payload word (or a header with last set) yields one verdict word.
//
// Output channel (out_valid / out_stall) is a single result register.
// A result is registered and shows on the output in the cycle after its
// input word is taken. The block takes one input word per cycle through the
// single register stage between input and result; the input is stalled only
// while a result waits in the register and the receiver stalls.
//
// Reset (rst, synchronous) empties the keyword table, the staging buffer
// and the packet state, and clears the last alerted pair to zero.
module packet_keyword_alert_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [7:0]  alert_code_in,
  input  logic [15:0] ether_type,
  input  logic [7:0]  ip_protocol,
  input  logic [31:0] source_addr,
  input  logic [31:0] dest_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [2:0]  status,
  output logic        alert,
  output logic [2:0]  keyword_slot,
  output logic [7:0]  alert_code_out,
  output logic [31:0] alert_source,
  output logic [31:0] alert_dest,
  output logic [3:0]  keyword_count
);
  import kam_pkg::*;

  logic                    accept;
  logic                    cmd_accept;
  logic                    hdr_accept;
  logic                    pay_accept;
  key_t                    window_next;
  logic [LEN_W-1:0]        seen_next;
  logic [MAX_KEYWORDS-1:0] match;
  code_vec_t               codes;
  logic [CNT_W-1:0]        count_next;
  logic [2:0]              cmd_status;
  table_edit_t             edit;
  verdict_t                verdict;

  // Hold the input only while a result sits unclaimed.
  assign in_stall   = out_valid && out_stall;
  assign accept     = in_valid && !in_stall;
  assign cmd_accept = accept && ((operation == OP_ADD) || (operation == OP_REMOVE));
  assign hdr_accept = accept && (operation == OP_HEADER);
  assign pay_accept = accept && (operation == OP_PAYLOAD);

  kam_keyword_table u_table (
    .clk           (clk),
    .rst           (rst),
    .cmd_accept    (cmd_accept),
    .cmd_remove    (operation == OP_REMOVE),
    .last          (last),
    .data_byte     (data_byte),
    .alert_code_in (alert_code_in),
    .window        (window_next),
    .seen          (seen_next),
    .match         (match),
    .codes         (codes),
    .count_next    (count_next),
    .status        (cmd_status),
    .edit          (edit)
  );

  kam_packet_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .hdr_accept  (hdr_accept),
    .pay_accept  (pay_accept),
    .last        (last),
    .data_byte   (data_byte),
    .ether_type  (ether_type),
    .ip_protocol (ip_protocol),
    .source_addr (source_addr),
    .dest_addr   (dest_addr),
    .match       (match),
    .codes       (codes),
    .edit        (edit),
    .window_next (window_next),
    .seen_next   (seen_next),
    .verdict     (verdict)
  );

  // Result register: load on a finishing word, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (accept && ((cmd_accept && last) || verdict.valid)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        keyword_count <= 4'(count_next);
        if (cmd_accept && last) begin
          result_kind    <= 1'b0;
          status         <= cmd_status;
          alert          <= 1'b0;
          keyword_slot   <= '0;
          alert_code_out <= '0;
          alert_source   <= '0;
          alert_dest     <= '0;
        end else if (verdict.valid) begin
          result_kind    <= 1'b1;
          status         <= ST_OK;
          alert          <= verdict.alert;
          keyword_slot   <= 3'(verdict.slot);
          alert_code_out <= verdict.code;
          alert_source   <= verdict.src;
          alert_dest     <= verdict.dst;
        end
      end
    end
  end

endmodule

// ===== design/kam_keyword_table.sv =====
module kam_keyword_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_accept,
  input  logic                        cmd_remove,
  input  logic                        last,
  input  logic [7:0]                  data_byte,
  input  logic [7:0]                  alert_code_in,
  input  kam_pkg::key_t               window,
  input  logic [kam_pkg::LEN_W-1:0]   seen,
  output logic [kam_pkg::MAX_KEYWORDS-1:0] match,
  output kam_pkg::code_vec_t          codes,
  output logic [kam_pkg::CNT_W-1:0]   count_next,
  output logic [2:0]                  status,
  output kam_pkg::table_edit_t        edit
);
  import kam_pkg::*;

  key_t             kw [MAX_KEYWORDS];
  logic [LEN_W-1:0] kw_len [MAX_KEYWORDS];
  logic [7:0]       kw_code_q [MAX_KEYWORDS];
  logic [CNT_W-1:0] count;
  key_t             stg;
  logic [LEN_W-1:0] stg_len;
  logic             stg_ovf;

  key_t             stg_next;
  logic [LEN_W-1:0] stg_len_next;
  logic             stg_ovf_next;
  logic [MAX_KEYWORDS-1:0] dup;
  logic             hit;
  logic [SLOT_W-1:0] hit_slot;
  logic             do_add;
  logic             do_remove;

  // Shift the new byte into the staging buffer; drop it once the buffer is full.
  always_comb begin
    stg_next     = stg;
    stg_len_next = stg_len;
    stg_ovf_next = stg_ovf;
    if (stg_len < LEN_W'(MAX_KEY_LEN)) begin
      stg_next     = {stg[MAX_KEY_LEN-2:0], data_byte};
      stg_len_next = stg_len + LEN_W'(1);
    end else begin
      stg_ovf_next = 1'b1;
    end
  end

  always_comb begin
    for (int s = 0; s < MAX_KEYWORDS; s++) begin
      dup[s]   = (CNT_W'(s) < count) && (kw_len[s] == stg_len_next);
      match[s] = (CNT_W'(s) < count) && (kw_len[s] != '0) && (kw_len[s] <= seen);
      for (int j = 0; j < MAX_KEY_LEN; j++) begin
        if (LEN_W'(j) < kw_len[s]) begin
          if (kw[s][j] != stg_next[j]) dup[s] = 1'b0;
          if (kw[s][j] != window[j])   match[s] = 1'b0;
        end
      end
      codes[s] = kw_code_q[s];
    end
  end

  always_comb begin
    hit      = |dup;
    hit_slot = '0;
    for (int s = MAX_KEYWORDS - 1; s >= 0; s--) begin
      if (dup[s]) hit_slot = SLOT_W'(s);
    end
  end

  always_comb begin
    do_add     = 1'b0;
    do_remove  = 1'b0;
    status     = ST_OK;
    count_next = count;
    if (cmd_accept && last) begin
      priority if (stg_ovf_next) begin
        status = ST_TOO_LONG;
      end else if (!cmd_remove) begin
        priority if (hit)                                status = ST_DUPLICATE;
        else if (count >= CNT_W'(MAX_KEYWORDS))          status = ST_FULL;
        else begin
          do_add     = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end else begin
        if (!hit) begin
          status = ST_NOT_FOUND;
        end else begin
          do_remove  = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
    end
    edit.remove = do_remove;
    edit.slot   = hit_slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      stg_len <= '0;
      stg_ovf <= 1'b0;
      for (int s = 0; s < MAX_KEYWORDS; s++) kw_len[s] <= '0;
    end else if (cmd_accept) begin
      stg     <= stg_next;
      count   <= count_next;
      stg_len <= last ? '0 : stg_len_next;
      stg_ovf <= last ? 1'b0 : stg_ovf_next;
      if (do_add) begin
        kw[count[SLOT_W-1:0]]        <= stg_next;
        kw_len[count[SLOT_W-1:0]]    <= stg_len_next;
        kw_code_q[count[SLOT_W-1:0]] <= alert_code_in;
      end
      // Compact: every slot from the hit upward takes its upper neighbor.
      if (do_remove) begin
        for (int s = 0; s < MAX_KEYWORDS; s++) begin
          if (SLOT_W'(s) >= hit_slot) begin
            if (s + 1 < MAX_KEYWORDS) begin
              kw[s]        <= kw[s+1];
              kw_len[s]    <= kw_len[s+1];
              kw_code_q[s] <= kw_code_q[s+1];
            end else begin
              kw_len[s] <= '0;
            end
          end
        end
      end
    end
  end

endmodule

// ===== design/kam_packet_tracker.sv =====
module kam_packet_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             hdr_accept,
  input  logic                             pay_accept,
  input  logic                             last,
  input  logic [7:0]                       data_byte,
  input  logic [15:0]                      ether_type,
  input  logic [7:0]                       ip_protocol,
  input  logic [31:0]                      source_addr,
  input  logic [31:0]                      dest_addr,
  input  logic [kam_pkg::MAX_KEYWORDS-1:0] match,
  input  kam_pkg::code_vec_t               codes,
  input  kam_pkg::table_edit_t             edit,
  output kam_pkg::key_t                    window_next,
  output logic [kam_pkg::LEN_W-1:0]        seen_next,
  output kam_pkg::verdict_t                verdict
);
  import kam_pkg::*;

  key_t                    window;
  logic [LEN_W-1:0]        seen;
  logic [MAX_KEYWORDS-1:0] found;
  logic                    active;
  logic [31:0]             pend_src;
  logic [31:0]             pend_dst;
  logic [31:0]             last_src;
  logic [31:0]             last_dst;

  logic [MAX_KEYWORDS-1:0] found_next;
  logic                    hdr_ok;
  logic                    alerting;
  logic [SLOT_W-1:0]       first_slot;

  assign window_next = {window[MAX_KEY_LEN-2:0], data_byte};
  assign seen_next   = (seen < LEN_W'(MAX_KEY_LEN)) ? seen + LEN_W'(1) : seen;
  assign hdr_ok      = (ether_type == ETHER_IPV4) && (ip_protocol == PROTO_TCP) &&
                       ((source_addr != last_src) || (dest_addr != last_dst));

  always_comb begin
    found_next = found;
    if (pay_accept && active) found_next = found | match;
    first_slot = '0;
    for (int s = MAX_KEYWORDS - 1; s >= 0; s--) begin
      if (found_next[s]) first_slot = SLOT_W'(s);
    end
    alerting = pay_accept && last && active && (|found_next);

    verdict       = '0;
    verdict.valid = (hdr_accept || pay_accept) && last;
    if (alerting) begin
      verdict.alert = 1'b1;
      verdict.slot  = first_slot;
      verdict.code  = codes[first_slot];
      verdict.src   = pend_src;
      verdict.dst   = pend_dst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      seen     <= '0;
      found    <= '0;
      active   <= 1'b0;
      pend_src <= '0;
      pend_dst <= '0;
      last_src <= '0;
      last_dst <= '0;
    end else begin
      if (hdr_accept) begin
        window   <= '0;
        seen     <= '0;
        found    <= '0;
        active   <= hdr_ok && !last;
        pend_src <= source_addr;
        pend_dst <= dest_addr;
      end else if (pay_accept) begin
        if (active) begin
          window <= window_next;
          seen   <= seen_next;
          found  <= found_next;
        end
        if (last) active <= 1'b0;
        if (alerting) begin
          last_src <= pend_src;
          last_dst <= pend_dst;
        end
      end else if (edit.remove) begin
        // Found marks move down with their slots.
        for (int s = 0; s < MAX_KEYWORDS; s++) begin
          if (SLOT_W'(s) >= edit.slot) begin
            if (s + 1 < MAX_KEYWORDS) found[s] <= found[s+1];
            else                      found[s] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_packet_keyword_alert_matcher.sv =====
module tb_packet_keyword_alert_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import kam_pkg::*;

  // One result word as seen on the output channel.
  typedef struct {
    logic        kind;
    logic [2:0]  stat;
    logic        hit;
    logic [2:0]  slot;
    logic [7:0]  code;
    logic [31:0] src;
    logic [31:0] dst;
    logic [3:0]  count;
  } result_t;

  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_WORDS = 1800;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  operation = '0;
  logic [7:0]  data_byte = '0;
  logic        last = 1'b0;
  logic [7:0]  alert_code_in = '0;
  logic [15:0] ether_type = '0;
  logic [7:0]  ip_protocol = '0;
  logic [31:0] source_addr = '0;
  logic [31:0] dest_addr = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        result_kind;
  logic [2:0]  status;
  logic        alert;
  logic [2:0]  keyword_slot;
  logic [7:0]  alert_code_out;
  logic [31:0] alert_source;
  logic [31:0] alert_dest;
  logic [3:0]  keyword_count;

  // Shared between the stimulus and the checker.
  result_t verdict_q[$];
  int      errors = 0;
  int      words_sent = 0;
  int      cycles = 0;
  bit      send_quiet = 0;   // sender adds no gaps while set
  bit      recv_quiet = 0;   // receiver adds no stalls while set
  int      hold_request = 0; // long receiver hold-off, picked up by the receiver

  // Mirror of the block state, updated once per accepted word.
  logic [7:0]  kw_chars[MAX_KEYWORDS][MAX_KEY_LEN];
  int          kw_len[MAX_KEYWORDS];
  logic [7:0]  kw_code[MAX_KEYWORDS];
  int          kw_count;
  logic [7:0]  stage_chars[MAX_KEY_LEN];
  int          stage_len;
  bit          stage_ovf;
  logic [7:0]  window[MAX_KEY_LEN];
  int          seen;
  bit          found[MAX_KEYWORDS];
  bit          pkt_active;
  logic [31:0] pend_src, pend_dst, last_src, last_dst;

  packet_keyword_alert_matcher i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .data_byte(data_byte), .last(last),
    .alert_code_in(alert_code_in), .ether_type(ether_type),
    .ip_protocol(ip_protocol), .source_addr(source_addr), .dest_addr(dest_addr),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .status(status), .alert(alert),
    .keyword_slot(keyword_slot), .alert_code_out(alert_code_out),
    .alert_source(alert_source), .alert_dest(alert_dest),
    .keyword_count(keyword_count)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[packet_keyword_alert_matcher] ERROR");
      $finish;
    end
  end

  function automatic void clear_packet_state();
    for (int i = 0; i < MAX_KEY_LEN; i++) window[i] = '0;
    for (int i = 0; i < MAX_KEYWORDS; i++) found[i] = 0;
    seen = 0;
  endfunction

  function automatic void reset_mirror();
    for (int i = 0; i < MAX_KEYWORDS; i++) begin
      kw_len[i] = 0;
      kw_code[i] = '0;
    end
    kw_count = 0;
    stage_len = 0;
    stage_ovf = 0;
    clear_packet_state();
    pkt_active = 0;
    pend_src = '0;
    pend_dst = '0;
    last_src = '0;
    last_dst = '0;
  endfunction

  // Slot holding the staged keyword, or -1.
  function automatic int staged_slot();
    bit same;
    for (int sl = 0; sl < kw_count; sl++) begin
      if (kw_len[sl] == stage_len) begin
        same = 1;
        for (int k = 0; k < stage_len; k++)
          if (kw_chars[sl][k] != stage_chars[k]) same = 0;
        if (same) return sl;
      end
    end
    return -1;
  endfunction

  // Advance the mirror by one accepted word and queue any result it causes.
  function automatic void match_engine_step(logic [1:0] op, logic [7:0] b, logic lst,
                                            logic [7:0] code, logic [15:0] eth,
                                            logic [7:0] pr, logic [31:0] sa,
                                            logic [31:0] da);
    result_t r;
    int      hit;
    int      len;
    bit      eq;
    r = '{default: '0};
    if (op == OP_ADD || op == OP_REMOVE) begin
      if (stage_len < MAX_KEY_LEN) begin
        stage_chars[stage_len] = b;
        stage_len++;
      end else begin
        stage_ovf = 1;
      end
      if (!lst) return;
      hit = stage_ovf ? -1 : staged_slot();
      if (stage_ovf) begin
        r.stat = ST_TOO_LONG;
      end else if (op == OP_ADD) begin
        if (hit >= 0) begin
          r.stat = ST_DUPLICATE;
        end else if (kw_count >= MAX_KEYWORDS) begin
          r.stat = ST_FULL;
        end else begin
          for (int k = 0; k < stage_len; k++) kw_chars[kw_count][k] = stage_chars[k];
          kw_len[kw_count] = stage_len;
          kw_code[kw_count] = code;
          found[kw_count] = 0;
          kw_count++;
          r.stat = ST_OK;
        end
      end else if (hit < 0) begin
        r.stat = ST_NOT_FOUND;
      end else begin
        // compact: found marks travel with their slots
        for (int sl = hit; sl + 1 < kw_count; sl++) begin
          kw_chars[sl] = kw_chars[sl + 1];
          kw_len[sl] = kw_len[sl + 1];
          kw_code[sl] = kw_code[sl + 1];
          found[sl] = found[sl + 1];
        end
        kw_count--;
        kw_len[kw_count] = 0;
        found[kw_count] = 0;
        r.stat = ST_OK;
      end
      stage_len = 0;
      stage_ovf = 0;
      r.count = 4'(kw_count);
      verdict_q.push_back(r);
      return;
    end
    r.kind = 1'b1;
    if (op == OP_HEADER) begin
      clear_packet_state();
      pkt_active = eth == ETHER_IPV4 && pr == PROTO_TCP &&
                   (sa != last_src || da != last_dst);
      pend_src = sa;
      pend_dst = da;
      if (!lst) return;
      pkt_active = 0;
      r.count = 4'(kw_count);
      verdict_q.push_back(r);
      return;
    end
    if (pkt_active) begin
      for (int i = MAX_KEY_LEN - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      if (seen < MAX_KEY_LEN) seen++;
      for (int sl = 0; sl < kw_count; sl++) begin
        len = kw_len[sl];
        eq = len != 0 && len <= seen;
        for (int k = 0; eq && k < len; k++)
          if (kw_chars[sl][k] != window[len - 1 - k]) eq = 0;
        if (eq) found[sl] = 1;
      end
    end
    if (!lst) return;
    if (pkt_active) begin
      for (int sl = 0; sl < kw_count; sl++) begin
        if (found[sl]) begin
          last_src = pend_src;
          last_dst = pend_dst;
          r.hit = 1'b1;
          r.slot = 3'(sl);
          r.code = kw_code[sl];
          r.src = pend_src;
          r.dst = pend_dst;
          break;
        end
      end
    end
    pkt_active = 0;
    r.count = 4'(kw_count);
    verdict_q.push_back(r);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycles, field, got, want);
    errors++;
  endtask

  // Receiver: check every taken result and draw its stall pattern.
  initial begin : receiver
    int      stall_left;
    int      hold_left;
    result_t w;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          if (verdict_q.size() == 0) begin
            report_mismatch("out_valid with nothing pending", 32'(1), 32'(0));
          end else begin
            w = verdict_q.pop_front();
            if (result_kind !== w.kind)
              report_mismatch("result_kind", 32'(result_kind), 32'(w.kind));
            if (status !== w.stat) report_mismatch("status", 32'(status), 32'(w.stat));
            if (alert !== w.hit) report_mismatch("alert", 32'(alert), 32'(w.hit));
            if (keyword_slot !== w.slot)
              report_mismatch("keyword_slot", 32'(keyword_slot), 32'(w.slot));
            if (alert_code_out !== w.code)
              report_mismatch("alert_code_out", 32'(alert_code_out), 32'(w.code));
            if (alert_source !== w.src) report_mismatch("alert_source", alert_source, w.src);
            if (alert_dest !== w.dst) report_mismatch("alert_dest", alert_dest, w.dst);
            if (keyword_count !== w.count)
              report_mismatch("keyword_count", 32'(keyword_count), 32'(w.count));
          end
          stall_left = recv_quiet ? 0 : $urandom_range(0, 3);
        end
        if (hold_request > 0) begin
          hold_left = hold_request;
          hold_request = 0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Send one word: wait out a random gap, offer it, hold until taken.
  task automatic send_word(logic [1:0] op, logic [7:0] b, logic lst, logic [7:0] code,
                           logic [15:0] eth, logic [7:0] pr, logic [31:0] sa,
                           logic [31:0] da);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operation <= op;
    data_byte <= b;
    last <= lst;
    alert_code_in <= code;
    ether_type <= eth;
    ip_protocol <= pr;
    source_addr <= sa;
    dest_addr <= da;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    match_engine_step(op, b, lst, code, eth, pr, sa, da);
    words_sent++;
  endtask

  // Header fields carry no meaning outside a header: fill them with noise.
  task automatic send_byte(logic [1:0] op, logic [7:0] b, logic lst, logic [7:0] code);
    send_word(op, b, lst, code, 16'($urandom), 8'($urandom), $urandom, $urandom);
  endtask

  task automatic send_keyword(logic [1:0] op, logic [7:0] chars[$], logic [7:0] code);
    foreach (chars[i])
      send_byte(op, chars[i], i == chars.size() - 1,
                (i == chars.size() - 1) ? code : 8'($urandom));
  endtask

  task automatic send_packet(logic [15:0] eth, logic [7:0] pr, logic [31:0] sa,
                             logic [31:0] da, logic [7:0] body[$]);
    send_word(OP_HEADER, 8'($urandom), body.size() == 0, 8'($urandom), eth, pr, sa, da);
    foreach (body[i]) send_byte(OP_PAYLOAD, body[i], i == body.size() - 1, 8'($urandom));
  endtask

  // Pause the sender until every pending result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    return ($urandom_range(0, 9) < 8) ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  function automatic void make_bytes(ref logic [7:0] q[$], input int n);
    q = {};
    repeat (n) q.push_back(pick_char());
  endfunction

  // Adds, duplicates, a full table, missing and too long keywords, mixed bytes.
  task automatic test_keyword_table();
    logic [7:0] q[$];
    q = {8'h00, 8'hff};
    send_keyword(OP_ADD, q, 8'hff);
    send_keyword(OP_ADD, q, 8'h01);           // duplicate
    q = {8'h61};
    send_keyword(OP_REMOVE, q, 8'h00);        // not present
    make_bytes(q, MAX_KEY_LEN);
    send_keyword(OP_ADD, q, 8'h22);           // exactly the longest length
    q.push_back(8'h61);
    send_keyword(OP_ADD, q, 8'h33);           // one byte too long
    send_keyword(OP_REMOVE, q, 8'h00);        // too long removal
    for (int i = 0; i < MAX_KEYWORDS - 1; i++) begin
      q = {8'h70 + 8'(i)};
      send_keyword(OP_ADD, q, 8'h40 + 8'(i));
    end
    q = {8'h7f};
    send_keyword(OP_ADD, q, 8'h00);           // table full
    q = {8'h71};
    send_keyword(OP_REMOVE, q, 8'h00);        // compacts the middle
    // add and remove bytes share the staging buffer; the last one decides
    send_byte(OP_REMOVE, 8'h71, 1'b0, 8'h00);
    send_byte(OP_ADD, 8'h71, 1'b1, 8'h99);
    drain();
  endtask

  // Header filters, empty payloads, orphan payload and abandoned packets.
  task automatic test_packet_filter();
    logic [7:0] q[$];
    q = {8'h70};
    send_packet(ETHER_IPV4, PROTO_TCP, '0, '0, q);          // zero pair rejected
    send_packet(16'h86dd, PROTO_TCP, 32'h1, 32'h2, q);      // not IPv4
    send_packet(ETHER_IPV4, 8'd17, 32'h1, 32'h2, q);        // not TCP
    q = {};
    send_packet(ETHER_IPV4, PROTO_TCP, 32'h1, 32'h2, q);    // empty payload
    send_byte(OP_PAYLOAD, 8'h70, 1'b1, 8'h00);              // no header
    q = {8'h00, 8'h70, 8'hff};
    send_packet(ETHER_IPV4, PROTO_TCP, 32'hffffffff, 32'h0a000001, q);
    send_packet(ETHER_IPV4, PROTO_TCP, 32'hffffffff, 32'h0a000001, q); // same pair again
    // header mid packet abandons the old one
    send_word(OP_HEADER, 8'h00, 1'b0, 8'h00, ETHER_IPV4, PROTO_TCP, 32'h5, 32'h6);
    send_byte(OP_PAYLOAD, 8'h72, 1'b0, 8'h00);
    q = {8'h73};
    send_packet(ETHER_IPV4, PROTO_TCP, 32'h7, 32'h8, q);
    // table change in the middle of a packet
    send_word(OP_HEADER, 8'h00, 1'b0, 8'h00, ETHER_IPV4, PROTO_TCP, 32'h9, 32'ha);
    send_byte(OP_PAYLOAD, 8'h74, 1'b0, 8'h00);
    q = {8'h70};
    send_keyword(OP_REMOVE, q, 8'h00);
    send_byte(OP_PAYLOAD, 8'h61, 1'b1, 8'h00);
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering header-only packets.
  task automatic test_backpressure();
    logic [7:0] q[$];
    q = {};
    hold_request = 60;
    send_quiet = 1;
    repeat (20)
      send_packet(ETHER_IPV4, PROTO_TCP, $urandom, $urandom, q);
    send_quiet = 0;
    drain();
  endtask

  // Mostly well formed keyword commands and packets with random content.
  task automatic test_random_traffic();
    logic [7:0]  q[$];
    logic [31:0] pairs[4];
    int          pick;
    int          sl;
    int          base;
    base = words_sent;
    pairs = '{32'h0, 32'h1, 32'hc0a80001, 32'hffffffff};
    while (words_sent - base < RANDOM_WORDS) begin
      if ($urandom_range(0, 99) < 3) begin
        send_quiet = !send_quiet;
        recv_quiet = 1'($urandom_range(0, 1));
      end
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        if (kw_count > 0 && $urandom_range(0, 3) == 0) begin
          sl = $urandom_range(0, kw_count - 1);
          q = {};
          for (int k = 0; k < kw_len[sl]; k++) q.push_back(kw_chars[sl][k]);
        end else begin
          make_bytes(q, ($urandom_range(0, 19) == 0) ? $urandom_range(28, 36)
                                                      : $urandom_range(1, 4));
        end
        send_keyword(OP_ADD, q, 8'($urandom));
      end else if (pick < 36) begin
        if (kw_count > 0 && $urandom_range(0, 9) < 7) begin
          sl = $urandom_range(0, kw_count - 1);
          q = {};
          for (int k = 0; k < kw_len[sl]; k++) q.push_back(kw_chars[sl][k]);
          if ($urandom_range(0, 9) == 0) q[0] = q[0] ^ 8'h01;
        end else begin
          make_bytes(q, $urandom_range(1, 4));
        end
        send_keyword(OP_REMOVE, q, 8'($urandom));
      end else if (pick < 88) begin
        make_bytes(q, ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                                  : $urandom_range(0, 12));
        if ($urandom_range(0, 9) < 8)
          send_packet(ETHER_IPV4, PROTO_TCP, pairs[$urandom_range(0, 3)],
                      pairs[$urandom_range(0, 3)], q);
        else
          send_packet(16'($urandom), 8'($urandom), $urandom, $urandom, q);
      end else begin
        // noise: any word with any fields
        send_word(2'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                  ($urandom_range(0, 1) ? ETHER_IPV4 : 16'($urandom)),
                  ($urandom_range(0, 1) ? PROTO_TCP : 8'($urandom)), $urandom, $urandom);
      end
    end
    // close any open keyword or packet so that it yields its result
    send_byte(OP_ADD, 8'h61, 1'b1, 8'h00);
    send_byte(OP_PAYLOAD, 8'h61, 1'b1, 8'h00);
    drain();
  endtask

  initial begin
    reset_mirror();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_keyword_table();
    test_packet_filter();
    test_backpressure();
    test_random_traffic();
    if (errors == 0)
      $display("[packet_keyword_alert_matcher] OK");
    else
      $display("[packet_keyword_alert_matcher] ERROR");
    $finish;
  end

endmodule
